// ----- design/cde_pkg.sv -----
// Package: shared types and constants of the crowding distance engine.
`default_nettype none
package cde_pkg;
	localparam int OBJ_FIELDS = 4;
	localparam int SUM_W = 19;
	localparam logic [17:0] DIV3_MUL = 18'd174763;
	localparam int DIV3_SHIFT = 19;

	typedef struct packed {
		logic [15:0] member_id;
		logic signed [31:0] objective_a;
		logic signed [31:0] objective_b;
		logic signed [31:0] objective_c;
		logic signed [31:0] objective_d;
		logic last_member;
	} in_item_t;

	typedef struct packed {
		logic [15:0] result_id;
		logic is_infinite;
		logic [16:0] distance;
		logic last_result;
	} out_item_t;

	typedef struct packed {
		logic valid;
		logic [15:0] id;
		logic [OBJ_FIELDS-1:0][31:0] obj;
		logic inf;
		logic interior;
		logic tail;
		logic [32:0] gap;
		logic [SUM_W-1:0] sum;
	} rec_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_SORT,
		OP_MARK,
		OP_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic parity;
		logic by_idx;
		logic [1:0] k;
		logic clr;
	} cell_ctrl_t;
endpackage
`default_nettype wire

// ----- design/crowding_distance_engine.sv -----
// Top level: crowding distance engine over one front, a chain of member cells.
// Members load one per cycle; the member flagged last starts the computation,
// during which no input is taken. Per objective in use the chain spends
// MAX_FRONT odd-even sort phases, a marking step, MAX_FRONT rotation steps to
// find the range, and MAX_FRONT more steps plus a shared serial divider run
// per interior member. The chain then re-sorts to load order in MAX_FRONT
// phases and delivers one result per cycle unless out_stall holds. Members
// beyond MAX_FRONT are dropped; a front of one or two members is all infinite.
`default_nettype none
module crowding_distance_engine #(
	parameter int MAX_FRONT = 64,
	parameter int MAX_OBJECTIVES = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire cde_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output cde_pkg::out_item_t      out_item,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_data
);
	import cde_pkg::*;

	localparam int IW = $clog2(MAX_FRONT);
	localparam int CW = $clog2(MAX_FRONT + 1);
	localparam int OCAP = (MAX_OBJECTIVES < OBJ_FIELDS) ? MAX_OBJECTIVES : OBJ_FIELDS;

	typedef enum logic [7:0] {
		S_LOAD  = 8'b00000001,
		S_SORT  = 8'b00000010,
		S_MARK  = 8'b00000100,
		S_SCAN  = 8'b00001000,
		S_ACC   = 8'b00010000,
		S_DIV   = 8'b00100000,
		S_OSORT = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	state_t        state_q;
	logic [2:0]    nobj_cfg_q;
	logic [2:0]    nobj;
	logic [CW-1:0] count_q;
	logic [CW-1:0] remain_q;
	logic [CW-1:0] step_q;
	logic [2:0]    k_q;
	logic signed [31:0] lo_q;
	logic signed [31:0] hi_q;
	logic [32:0]   range_q;
	logic          out_valid_q;
	out_item_t     out_q;

	rec_t          recs [MAX_FRONT];
	logic [IW-1:0] idxs [MAX_FRONT];
	rec_t          wrap_rec;
	cell_ctrl_t    ctrl;
	logic          in_xfer;
	logic          out_free;
	logic          div_start;
	logic          div_done;
	logic [16:0]   div_q;
	logic [16:0]   add_v;
	rec_t          head;
	logic          need_div;
	logic [SUM_W-1:0] fin;
	logic [SUM_W+17:0] prod3;

	assign nobj = (nobj_cfg_q == 3'd0) ? 3'd1
		: (nobj_cfg_q > 3'(OCAP)) ? 3'(OCAP) : nobj_cfg_q;

	assign head = recs[0];
	assign in_stall = state_q != S_LOAD;
	assign in_xfer = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign need_div = head.interior && (range_q != 33'd0);
	assign add_v = (state_q == S_DIV) ? div_q : 17'd0;

	always_comb begin
		wrap_rec = head;
		wrap_rec.sum = head.sum + SUM_W'(add_v);
	end

	always_comb begin
		ctrl.op = OP_HOLD;
		ctrl.parity = step_q[0];
		ctrl.by_idx = state_q == S_OSORT;
		ctrl.k = k_q[1:0];
		ctrl.clr = count_q == '0;
		div_start = 1'b0;
		case (state_q)
			S_LOAD: if (in_xfer) ctrl.op = OP_LOAD;
			S_SORT, S_OSORT: if (step_q != CW'(MAX_FRONT)) ctrl.op = OP_SORT;
			S_MARK: ctrl.op = OP_MARK;
			S_SCAN: if (step_q != CW'(MAX_FRONT)) ctrl.op = OP_ROT;
			S_ACC: begin
				if (step_q != CW'(MAX_FRONT)) begin
					if (need_div)
						div_start = 1'b1;
					else
						ctrl.op = OP_ROT;
				end
			end
			S_DIV: if (div_done) ctrl.op = OP_ROT;
			S_OUT: if (out_free && remain_q != '0) ctrl.op = OP_ROT;
			default: ctrl.op = OP_HOLD;
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_FRONT; gi++) begin : g_cell
			rec_t          l_rec;
			rec_t          r_rec;
			logic [IW-1:0] l_idx;
			logic [IW-1:0] r_idx;
			if (gi == 0) begin : g_l0
				assign l_rec = '0;
				assign l_idx = '0;
			end else begin : g_l
				assign l_rec = recs[gi-1];
				assign l_idx = idxs[gi-1];
			end
			if (gi == MAX_FRONT - 1) begin : g_rw
				assign r_rec = wrap_rec;
				assign r_idx = idxs[0];
			end else begin : g_r
				assign r_rec = recs[gi+1];
				assign r_idx = idxs[gi+1];
			end
			cde_cell #(.MAX_FRONT(MAX_FRONT), .IDX(gi)) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctrl(ctrl),
				.ld_sel(count_q == CW'(gi)),
				.ld_item(in_item),
				.left_rec(l_rec),
				.left_idx(l_idx),
				.right_rec(r_rec),
				.right_idx(r_idx),
				.rec_q(recs[gi]),
				.idx_q(idxs[gi])
			);
		end
	endgenerate

	cde_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.gap(head.gap),
		.range(range_q),
		.quot(div_q),
		.done(div_done)
	);

	always_comb begin
		prod3 = (SUM_W+18)'(head.sum) * (SUM_W+18)'(DIV3_MUL);
		case (nobj)
			3'd2: fin = head.sum >> 1;
			3'd3: fin = SUM_W'(prod3 >> DIV3_SHIFT);
			3'd4: fin = head.sum >> 2;
			default: fin = head.sum;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			nobj_cfg_q <= 3'd2;
			count_q <= '0;
			remain_q <= '0;
			step_q <= '0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				nobj_cfg_q <= cfg_data;
			out_valid_q <= (state_q == S_OUT && remain_q != '0 && out_free)
				|| (out_valid_q && out_stall);
			case (state_q)
				S_LOAD: begin
					if (in_xfer) begin
						if (in_item.last_member) begin
							remain_q <= (count_q < CW'(MAX_FRONT)) ? CW'(count_q + 1'b1)
								: count_q;
							count_q <= '0;
							step_q <= '0;
							k_q <= '0;
							state_q <= S_SORT;
						end else if (count_q < CW'(MAX_FRONT)) begin
							count_q <= CW'(count_q + 1'b1);
						end
					end
				end
				S_SORT: begin
					if (step_q == CW'(MAX_FRONT)) begin
						step_q <= '0;
						state_q <= S_MARK;
					end else begin
						step_q <= CW'(step_q + 1'b1);
					end
				end
				S_MARK: state_q <= S_SCAN;
				S_SCAN: begin
					if (step_q == CW'(MAX_FRONT)) begin
						range_q <= 33'({hi_q[31], hi_q} - {lo_q[31], lo_q});
						step_q <= '0;
						state_q <= S_ACC;
					end else begin
						if (step_q == '0)
							lo_q <= $signed(head.obj[k_q[1:0]]);
						if (head.tail)
							hi_q <= $signed(head.obj[k_q[1:0]]);
						step_q <= CW'(step_q + 1'b1);
					end
				end
				S_ACC: begin
					if (step_q == CW'(MAX_FRONT)) begin
						step_q <= '0;
						if (3'(k_q + 1'b1) == nobj) begin
							state_q <= S_OSORT;
						end else begin
							k_q <= 3'(k_q + 1'b1);
							state_q <= S_SORT;
						end
					end else if (need_div) begin
						state_q <= S_DIV;
					end else begin
						step_q <= CW'(step_q + 1'b1);
					end
				end
				S_DIV: begin
					if (div_done) begin
						step_q <= CW'(step_q + 1'b1);
						state_q <= S_ACC;
					end
				end
				S_OSORT: begin
					if (step_q == CW'(MAX_FRONT)) begin
						step_q <= '0;
						state_q <= S_OUT;
					end else begin
						step_q <= CW'(step_q + 1'b1);
					end
				end
				S_OUT: begin
					if (remain_q == '0) begin
						state_q <= S_LOAD;
					end else if (out_free) begin
						remain_q <= CW'(remain_q - 1'b1);
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && remain_q != '0 && out_free) begin
			out_q.result_id <= head.id;
			out_q.is_infinite <= head.inf;
			out_q.distance <= head.inf ? 17'd0 : fin[16:0];
			out_q.last_result <= remain_q == CW'(1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;
endmodule
`default_nettype wire

// ----- design/cde_div.sv -----
// Iterative restoring divider: floor(gap * 65536 / range), one quotient bit per cycle.
`default_nettype none
module cde_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [32:0] gap,
	input  wire logic [32:0] range,
	output logic      [16:0] quot,
	output logic             done
);
	import cde_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic        first_q;
	logic [4:0]  cnt_q;
	logic [32:0] rem_q;
	logic [32:0] den_q;
	logic        nb_q;
	logic [16:0] q_q;
	logic [33:0] trial;
	logic        ge;

	assign trial = {rem_q, (first_q ? nb_q : 1'b0)};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			first_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				first_q <= 1'b1;
				cnt_q <= 5'd16;
			end else if (busy_q) begin
				first_q <= 1'b0;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, gap[32:1]};
			nb_q <= gap[0];
			den_q <= range;
			q_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 33'(trial - {1'b0, den_q}) : trial[32:0];
			q_q <= {q_q[15:0], ge};
		end
	end

	assign quot = q_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ----- design/cde_cell.sv -----
// One member slot of the chain: load, neighbor compare-swap, edge marking, rotation.
`default_nettype none
module cde_cell #(
	parameter int MAX_FRONT = 64,
	parameter int IDX = 0
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cde_pkg::cell_ctrl_t          ctrl,
	input  wire logic                         ld_sel,
	input  wire cde_pkg::in_item_t            ld_item,
	input  wire cde_pkg::rec_t                left_rec,
	input  wire logic [$clog2(MAX_FRONT)-1:0] left_idx,
	input  wire cde_pkg::rec_t                right_rec,
	input  wire logic [$clog2(MAX_FRONT)-1:0] right_idx,
	output cde_pkg::rec_t                     rec_q,
	output logic [$clog2(MAX_FRONT)-1:0]      idx_q
);
	import cde_pkg::*;

	localparam int IW = $clog2(MAX_FRONT);
	localparam logic ODD = 1'(IDX % 2);
	localparam logic HAS_L = IDX > 0;
	localparam logic HAS_R = IDX < MAX_FRONT - 1;

	function automatic logic key_gt(rec_t a, logic [IW-1:0] ai, rec_t b,
			logic [IW-1:0] bi, logic by_idx, logic [1:0] k);
		logic signed [31:0] av;
		logic signed [31:0] bv;
		av = $signed(a.obj[k]);
		bv = $signed(b.obj[k]);
		if (by_idx)
			return ai > bi;
		return (av > bv) || ((av == bv) && (ai > bi));
	endfunction

	logic          me_left;
	logic          partner_ok;
	rec_t          partner;
	logic [IW-1:0] partner_idx;
	logic          swap;
	logic          nxt_valid;
	logic          is_last;

	always_comb begin
		me_left = ctrl.parity == ODD;
		partner = me_left ? right_rec : left_rec;
		partner_idx = me_left ? right_idx : left_idx;
		partner_ok = me_left ? HAS_R : HAS_L;
		if (me_left)
			swap = partner_ok && rec_q.valid && partner.valid
				&& key_gt(rec_q, idx_q, partner, partner_idx, ctrl.by_idx, ctrl.k);
		else
			swap = partner_ok && rec_q.valid && partner.valid
				&& key_gt(partner, partner_idx, rec_q, idx_q, ctrl.by_idx, ctrl.k);
		nxt_valid = HAS_R ? right_rec.valid : 1'b0;
		is_last = rec_q.valid && !nxt_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
			idx_q <= '0;
		end else begin
			case (ctrl.op)
				OP_LOAD: begin
					if (ld_sel) begin
						rec_q.valid <= 1'b1;
						rec_q.id <= ld_item.member_id;
						rec_q.obj <= {ld_item.objective_d, ld_item.objective_c,
							ld_item.objective_b, ld_item.objective_a};
						rec_q.inf <= 1'b0;
						rec_q.sum <= '0;
						idx_q <= IW'(IDX);
					end else if (ctrl.clr) begin
						rec_q.valid <= 1'b0;
					end
				end
				OP_SORT: begin
					if (swap) begin
						rec_q <= partner;
						idx_q <= partner_idx;
					end
				end
				OP_MARK: begin
					rec_q.inf <= rec_q.inf || (rec_q.valid && (!HAS_L || is_last));
					rec_q.interior <= rec_q.valid && HAS_L && !is_last;
					rec_q.tail <= is_last;
					rec_q.gap <= 33'({right_rec.obj[ctrl.k][31], right_rec.obj[ctrl.k]}
						- {left_rec.obj[ctrl.k][31], left_rec.obj[ctrl.k]});
				end
				OP_ROT: begin
					rec_q <= right_rec;
					idx_q <= right_idx;
				end
				default: begin
				end
			endcase
		end
	end
endmodule
`default_nettype wire
